// ===== design/sha256hc_pkg.sv =====
// Shared types, constants and SHA-256 helper functions for the hash core.
// No dependencies; imported by the interfaces, the round and the top level.
`default_nettype none

package sha256hc_pkg;

	typedef logic [31:0] word_t;

	// Working variables a..h; element 0 is a, element 7 is h.
	typedef logic [7:0][31:0] hstate_t;

	localparam int unsigned BLK_WORDS  = 16;
	localparam int unsigned HASH_WORDS = 8;
	localparam int unsigned ROUNDS     = 64;

	localparam logic [3:0] LEN_HI_POS  = 4'd14;
	localparam logic [3:0] LEN_LO_POS  = 4'd15;
	localparam logic [2:0] LAST_IDX    = 3'd7;
	localparam logic [5:0] LAST_ROUND  = 6'd63;
	localparam logic [2:0] FULL_BYTES  = 3'd4;
	localparam word_t      PAD_WORD    = 32'h8000_0000;

	localparam word_t ROUND_K [0:63] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	localparam word_t INIT_HASH [0:7] = '{
		32'h6A09E667, 32'hBB67AE85, 32'h3C6EF372, 32'hA54FF53A,
		32'h510E527F, 32'h9B05688C, 32'h1F83D9AB, 32'h5BE0CD19
	};

	// Upper-case sigma of the a word.
	function automatic word_t big_sigma0(input word_t x);
		return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
	endfunction

	// Upper-case sigma of the e word.
	function automatic word_t big_sigma1(input word_t x);
		return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
	endfunction

	// Message schedule sigma applied to w[i-15].
	function automatic word_t small_sigma0(input word_t x);
		return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
	endfunction

	// Message schedule sigma applied to w[i-2].
	function automatic word_t small_sigma1(input word_t x);
		return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
	endfunction

endpackage

`default_nettype wire

// ===== design/sha256hc_if.sv =====
// Valid/ready channel interfaces for message items and digest items.
// Depends on sha256hc_pkg for the word type.
`default_nettype none

interface sha256hc_msg_if import sha256hc_pkg::*; ();
	logic       valid;
	logic       ready;
	word_t      data_word;
	logic [2:0] bytes_valid;
	logic       end_of_message;

	modport source (output valid, output data_word, output bytes_valid,
		output end_of_message, input ready);
	modport sink (input valid, input data_word, input bytes_valid,
		input end_of_message, output ready);
endinterface

interface sha256hc_digest_if import sha256hc_pkg::*; ();
	logic       valid;
	logic       ready;
	word_t      digest_word;
	logic [2:0] word_index;
	logic       last_word;

	modport source (output valid, output digest_word, output word_index,
		output last_word, input ready);
	modport sink (input valid, input digest_word, input word_index,
		input last_word, output ready);
endinterface

`default_nettype wire

// ===== design/sha256hc_ram.sv =====
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
`default_nettype none

module sha256hc_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write and registered read; a read in the cycle after a write sees the new data.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

// ===== design/sha256hc_round.sv =====
// One SHA-256 compression round on the working variables a..h.
// Depends on sha256hc_pkg for the round constants and sigma functions.
`default_nettype none

module sha256hc_round import sha256hc_pkg::*; (
	input  wire hstate_t    cur,
	input  wire word_t      w,
	input  wire logic [5:0] round,
	output hstate_t         nxt
);

	word_t ch;
	word_t mj;
	word_t t1;
	word_t t2;

	// Choice and majority, then the two temporaries.
	assign ch = (cur[4] & cur[5]) ^ (~cur[4] & cur[6]);
	assign mj = (cur[0] & cur[1]) ^ (cur[0] & cur[2]) ^ (cur[1] & cur[2]);
	assign t1 = cur[7] + big_sigma1(cur[4]) + ch + ROUND_K[round] + w;
	assign t2 = big_sigma0(cur[0]) + mj;

	// Rotate the working variables.
	always_comb begin
		nxt[0] = t1 + t2;
		nxt[1] = cur[0];
		nxt[2] = cur[1];
		nxt[3] = cur[2];
		nxt[4] = cur[3] + t1;
		nxt[5] = cur[4];
		nxt[6] = cur[5];
		nxt[7] = cur[6];
	end

endmodule

`default_nettype wire

// ===== design/sha256hc_top.sv =====
// SHA-256 hash core top level: control sequencer, block and hash memories.
// Depends on sha256hc_pkg, sha256hc_if, sha256hc_ram and sha256hc_round.
//
// SHA-256 over a byte message given as big-endian 32-bit items. The core takes
// one item at a time and only while idle. Filling the 16-word block starts a
// compression: the hash words are loaded from the hash memory, a read and a
// capture state per word; 64 rounds follow, of which the first 16 read their
// word and run the round, and the other 48 fetch four words through the single
// read port of the block memory and write the new schedule word back first;
// then the result is added back into the hash memory, a read and a write state
// per word. The final item writes its padding one word per cycle and may cause
// one extra block. The eight digest items then leave in order, each offered
// until the sink takes it, and the core returns to the initial hash state.
`default_nettype none

module sha256_hash_core_top import sha256hc_pkg::*; (
	input  wire logic          clk,
	input  wire logic          arst_n,
	sha256hc_msg_if.sink       msg,
	sha256hc_digest_if.source  digest
);

	typedef enum logic [3:0] {
		ST_IDLE, ST_PAD, ST_LD_RD, ST_LD_CAP, ST_RD0, ST_RD1, ST_RD2, ST_RD3,
		ST_WB, ST_RND, ST_UP_RD, ST_UP_WR, ST_OUT_RD, ST_OUT_LD, ST_OUT_WAIT
	} state_t;

	state_t      state_q;
	logic [3:0]  pos_q;
	logic [63:0] len_q;
	logic        final_q;
	logic        pend_q;
	logic        lenok_q;
	logic        done_q;
	logic        hinit_q;
	logic [2:0]  hidx_q;
	logic [5:0]  round_q;
	word_t       acc_q;
	word_t       w_q;
	word_t       out_word_q;
	hstate_t     s_q;

	hstate_t     s_next;
	logic        msg_acc;
	logic        dig_acc;
	logic [2:0]  nb_c;
	word_t       first_word;
	word_t       pad_word_c;
	word_t       w_new;
	word_t       h_base;
	logic        fin_wr;
	logic        pad_here;

	logic        b_we;
	logic [3:0]  b_waddr;
	word_t       b_wdata;
	logic [3:0]  b_raddr;
	word_t       b_rdata;
	logic        h_we;
	word_t       h_wdata;
	logic [2:0]  h_raddr;
	word_t       h_rdata;

	assign msg_acc = msg.valid && msg.ready;
	assign dig_acc = digest.valid && digest.ready;

	// Handshake and digest payload come straight from registers.
	assign msg.ready          = (state_q == ST_IDLE);
	assign digest.valid       = (state_q == ST_OUT_WAIT);
	assign digest.digest_word = out_word_q;
	assign digest.word_index  = hidx_q;
	assign digest.last_word   = (hidx_q == LAST_IDX);

	// Byte count of the final item, with counts above four taken as four.
	assign nb_c = (msg.bytes_valid > FULL_BYTES) ? FULL_BYTES : msg.bytes_valid;

	// Final item word: keep the valid leading bytes and place the pad byte after them when fewer than four are valid.
	always_comb begin
		case (nb_c)
			3'd0:    first_word = PAD_WORD;
			3'd1:    first_word = {msg.data_word[31:24], 24'h80_0000};
			3'd2:    first_word = {msg.data_word[31:16], 16'h8000};
			3'd3:    first_word = {msg.data_word[31:8], 8'h80};
			default: first_word = msg.data_word;
		endcase
	end

	// Padding word for the current position.
	always_comb begin
		if (pend_q) begin
			pad_word_c = PAD_WORD;
		end else if (lenok_q && pos_q == LEN_HI_POS) begin
			pad_word_c = len_q[63:32];
		end else if (lenok_q && pos_q == LEN_LO_POS) begin
			pad_word_c = len_q[31:0];
		end else begin
			pad_word_c = '0;
		end
	end

	// A write made while the message is being closed, and whether it holds the pad byte.
	assign fin_wr   = (msg_acc && msg.end_of_message) || (state_q == ST_PAD);
	assign pad_here = (msg_acc && msg.end_of_message && nb_c != FULL_BYTES)
		|| (state_q == ST_PAD && pend_q);

	// New schedule word from the four fetched words.
	assign w_new  = acc_q + small_sigma1(b_rdata);
	// Hash word before this block; the initial value until the first update.
	assign h_base = hinit_q ? h_rdata : INIT_HASH[hidx_q];

	// Block memory port control.
	always_comb begin
		b_we    = 1'b0;
		b_waddr = pos_q;
		b_wdata = msg.data_word;
		b_raddr = round_q[3:0];
		if (msg_acc) begin
			b_we    = 1'b1;
			b_wdata = msg.end_of_message ? first_word : msg.data_word;
		end
		unique case (state_q)
			ST_PAD: begin
				b_we    = 1'b1;
				b_wdata = pad_word_c;
			end
			ST_RD1:  b_raddr = round_q[3:0] + 4'd1;
			ST_RD2:  b_raddr = round_q[3:0] + 4'd9;
			ST_RD3:  b_raddr = round_q[3:0] + 4'd14;
			ST_WB: begin
				b_we    = 1'b1;
				b_waddr = round_q[3:0];
				b_wdata = w_new;
			end
			default: ;
		endcase
	end

	// Hash memory port control.
	assign h_raddr = hidx_q;
	assign h_we    = (state_q == ST_UP_WR);
	assign h_wdata = h_base + s_q[hidx_q];

	sha256hc_ram #(.WIDTH(32), .DEPTH(BLK_WORDS)) u_block_ram (
		.clk   (clk),
		.we    (b_we),
		.waddr (b_waddr),
		.wdata (b_wdata),
		.raddr (b_raddr),
		.rdata (b_rdata)
	);

	sha256hc_ram #(.WIDTH(32), .DEPTH(HASH_WORDS)) u_hash_ram (
		.clk   (clk),
		.we    (h_we),
		.waddr (hidx_q),
		.wdata (h_wdata),
		.raddr (h_raddr),
		.rdata (h_rdata)
	);

	sha256hc_round u_round (
		.cur   (s_q),
		.w     (w_q),
		.round (round_q),
		.nxt   (s_next)
	);

	// Sequencer: message intake, padding, compression and digest output.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			pos_q      <= '0;
			len_q      <= '0;
			final_q    <= 1'b0;
			pend_q     <= 1'b0;
			lenok_q    <= 1'b0;
			done_q     <= 1'b0;
			hinit_q    <= 1'b0;
			hidx_q     <= '0;
			round_q    <= '0;
			acc_q      <= '0;
			w_q        <= '0;
			out_word_q <= '0;
			s_q        <= '0;
		end else begin
			// Length bookkeeping on writes that close the message.
			if (fin_wr) begin
				if (pos_q == LEN_LO_POS) begin
					if (lenok_q) begin
						done_q <= 1'b1;
					end else begin
						lenok_q <= 1'b1;
					end
				end else if (pad_here && pos_q < LEN_HI_POS) begin
					lenok_q <= 1'b1;
				end
			end
			unique case (state_q)
				ST_IDLE: begin
					if (msg_acc) begin
						pos_q <= pos_q + 4'd1;
						if (msg.end_of_message) begin
							len_q   <= len_q + {{58{1'b0}}, nb_c, 3'b000};
							final_q <= 1'b1;
							pend_q  <= (nb_c == FULL_BYTES);
						end else begin
							len_q <= len_q + 64'd32;
						end
						if (pos_q == LEN_LO_POS) begin
							hidx_q  <= '0;
							state_q <= ST_LD_RD;
						end else if (msg.end_of_message) begin
							state_q <= ST_PAD;
						end
					end
				end
				ST_PAD: begin
					pos_q  <= pos_q + 4'd1;
					pend_q <= 1'b0;
					if (pos_q == LEN_LO_POS) begin
						hidx_q  <= '0;
						state_q <= ST_LD_RD;
					end
				end
				ST_LD_RD: state_q <= ST_LD_CAP;
				ST_LD_CAP: begin
					s_q[hidx_q] <= h_base;
					hidx_q      <= hidx_q + 3'd1;
					if (hidx_q == LAST_IDX) begin
						round_q <= '0;
						state_q <= ST_RD0;
					end else begin
						state_q <= ST_LD_RD;
					end
				end
				ST_RD0: state_q <= ST_RD1;
				ST_RD1: begin
					if (round_q[5:4] == 2'b00) begin
						w_q     <= b_rdata;
						state_q <= ST_RND;
					end else begin
						acc_q   <= b_rdata;
						state_q <= ST_RD2;
					end
				end
				ST_RD2: begin
					acc_q   <= acc_q + small_sigma0(b_rdata);
					state_q <= ST_RD3;
				end
				ST_RD3: begin
					acc_q   <= acc_q + b_rdata;
					state_q <= ST_WB;
				end
				ST_WB: begin
					w_q     <= w_new;
					state_q <= ST_RND;
				end
				ST_RND: begin
					s_q     <= s_next;
					round_q <= round_q + 6'd1;
					if (round_q == LAST_ROUND) begin
						hidx_q  <= '0;
						state_q <= ST_UP_RD;
					end else begin
						state_q <= ST_RD0;
					end
				end
				ST_UP_RD: state_q <= ST_UP_WR;
				ST_UP_WR: begin
					hidx_q <= hidx_q + 3'd1;
					if (hidx_q == LAST_IDX) begin
						hinit_q <= 1'b1;
						if (done_q) begin
							state_q <= ST_OUT_RD;
						end else if (final_q) begin
							state_q <= ST_PAD;
						end else begin
							state_q <= ST_IDLE;
						end
					end else begin
						state_q <= ST_UP_RD;
					end
				end
				ST_OUT_RD: state_q <= ST_OUT_LD;
				ST_OUT_LD: begin
					out_word_q <= h_rdata;
					state_q    <= ST_OUT_WAIT;
				end
				ST_OUT_WAIT: begin
					if (dig_acc) begin
						if (hidx_q == LAST_IDX) begin
							hidx_q  <= '0;
							pos_q   <= '0;
							len_q   <= '0;
							final_q <= 1'b0;
							pend_q  <= 1'b0;
							lenok_q <= 1'b0;
							done_q  <= 1'b0;
							hinit_q <= 1'b0;
							state_q <= ST_IDLE;
						end else begin
							hidx_q  <= hidx_q + 3'd1;
							state_q <= ST_OUT_RD;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Input and output never handshake in the same cycle.
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		msg.ready |-> !digest.valid)
		else $error("input ready while a digest item is offered");

	// Schedule write-back happens only for rounds that extend the schedule.
	a_wb_round: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_WB |-> round_q[5:4] != 2'b00)
		else $error("schedule write-back in one of the first sixteen rounds");

	// Digest output only after the length words went into a compressed block.
	a_out_done: assert property (@(posedge clk) disable iff (!arst_n)
		digest.valid |-> done_q && hinit_q && final_q)
		else $error("digest offered before the padded message was compressed");

	// The last digest item returns the core to its initial state.
	a_restart: assert property (@(posedge clk) disable iff (!arst_n)
		dig_acc && digest.last_word |=> pos_q == 4'd0 && len_q == 64'd0 && !hinit_q
			&& state_q == ST_IDLE)
		else $error("core not restarted after the last digest item");

endmodule

`default_nettype wire
